### sv/lru_kv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lru_kv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int RANK_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int THR_W       = RANK_W + 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef struct packed {
    op_t                     opcode;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] store_value;
  } req_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] used;
  } store_stat_t;

endpackage

`default_nettype wire

### sv/lru_kv_store.sv
`timescale 1ns / 1ps
`default_nettype none

module lru_kv_store
  import lru_kv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire req_t             req,
  input  wire logic [CNT_W-1:0] cap,
  output rsp_t                  rsp,
  output store_stat_t           stat
);

  logic signed [KEY_W-1:0] keys   [MAX_ENTRIES];
  logic signed [VAL_W-1:0] values [MAX_ENTRIES];
  logic [RANK_W-1:0]       rank   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  valid;
  logic [CNT_W-1:0]        used;

  logic [MAX_ENTRIES-1:0]  hit_oh;
  logic [MAX_ENTRIES-1:0]  free_vec;
  logic [MAX_ENTRIES-1:0]  free_oh;
  logic [MAX_ENTRIES-1:0]  lru_oh;
  logic [MAX_ENTRIES-1:0]  tgt_oh;
  logic                    hit_any;
  logic                    room;
  logic                    is_put;
  logic                    insert;
  logic                    upd;
  logic [RANK_W-1:0]       lru_rank;
  logic [RANK_W-1:0]       sel_rank;
  logic signed [VAL_W-1:0] sel_value;
  logic [THR_W-1:0]        thresh;

  always_comb begin
    lru_rank = RANK_W'(used - CNT_W'(1));
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_oh[i] = valid[i] && (keys[i] == req.lookup_key);
      lru_oh[i] = valid[i] && (rank[i] == lru_rank);
    end
    hit_any  = |hit_oh;
    free_vec = ~valid;
    free_oh  = free_vec & (~free_vec + MAX_ENTRIES'(1));
    room     = used < cap;
    is_put   = req.opcode == OP_PUT;
    insert   = is_put && !hit_any && room;
    upd      = fire && (is_put || hit_any);

    priority if (hit_any) begin
      tgt_oh = hit_oh;
    end else if (room) begin
      tgt_oh = free_oh;
    end else begin
      tgt_oh = lru_oh;
    end

    sel_rank  = '0;
    sel_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      sel_rank  = sel_rank  | (rank[i]   & {RANK_W{tgt_oh[i]}});
      sel_value = sel_value | (values[i] & {VAL_W{tgt_oh[i]}});
    end

    // a fresh insert ages every valid entry
    thresh = insert ? THR_W'(MAX_ENTRIES) : {1'b0, sel_rank};

    rsp.found      = hit_any;
    rsp.read_value = hit_any ? sel_value : '1;
    stat.used      = used;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      used  <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (upd) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (tgt_oh[i]) begin
          rank[i] <= '0;
        end else if (valid[i] && ({1'b0, rank[i]} < thresh)) begin
          rank[i] <= rank[i] + RANK_W'(1);
        end
      end
      if (insert) begin
        valid <= valid | free_oh;
        used  <= used + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_put) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (tgt_oh[i]) begin
          keys[i]   <= req.lookup_key;
          values[i] <= req.store_value;
        end
      end
    end
  end

endmodule

`default_nettype wire

### sv/lru_key_value_cache.sv
// lru_key_value_cache: 16-entry fully associative key/value store, LRU replacement.
// Request channel (req_valid / req_stall / req): a get or a put per transaction.
// Response channel (rsp_valid / rsp_stall / rsp): one transaction per get,
// none per put. A get miss returns found = 0 and read_value all ones.
// Config channel (cfg_valid / cfg_ready / cfg_data): capacity_in_use, always
// ready; 0 acts as 1, above 16 acts as 16. Write only while idle.
// A request is registered on acceptance and resolved from that register; a get's
// result goes into the response register, from which it is taken while
// rsp_stall is low. Throughput is one request per cycle while req_stall is low:
// key compare and rank update across all entries are done between the request
// and response registers.
// A put never waits for the response side. A get held in the request
// register waits while a response is stalled, and req_stall is then raised.
// Reset (synchronous, active high) empties the store, drops any pending
// request and response, and sets the capacity to 16.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache
  import lru_kv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire req_t             req,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output rsp_t                  rsp,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_data
);

  logic             hold_valid;
  req_t             hold;
  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] eff_cap;
  logic             out_free;
  logic             proceed;
  logic             is_get;
  rsp_t             store_rsp;
  store_stat_t      stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if ({{(32-CAP_W){1'b0}}, capacity} > MAX_ENTRIES) begin
      eff_cap = CNT_W'(MAX_ENTRIES);
    end else begin
      eff_cap = CNT_W'(capacity);
    end
    is_get    = hold.opcode == OP_GET;
    out_free  = !rsp_valid || !rsp_stall;
    proceed   = hold_valid && (!is_get || out_free);
    req_stall = hold_valid && !proceed;
  end

  lru_kv_store u_store (
    .clk  (clk),
    .rst  (rst),
    .fire (proceed),
    .req  (hold),
    .cap  (eff_cap),
    .rsp  (store_rsp),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        hold_valid <= 1'b1;
      end else if (proceed) begin
        hold_valid <= 1'b0;
      end
      if (proceed && is_get) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      hold <= req;
    end
    if (proceed && is_get) begin
      rsp <= store_rsp;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    {{(32-CNT_W){1'b0}}, stat.used} <= MAX_ENTRIES)
    else $error("occupancy above store size");

  a_used_cap: assert property (@(posedge clk) disable iff (rst)
    proceed && !is_get && (stat.used < eff_cap) |=> stat.used != '0)
    else $error("store empty after put");

  a_put_silent: assert property (@(posedge clk) disable iff (rst)
    proceed && !is_get && !rsp_valid |=> !rsp_valid)
    else $error("response raised by a put");

  a_get_rsp: assert property (@(posedge clk) disable iff (rst)
    proceed && is_get |=> rsp_valid)
    else $error("get resolved without response");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> hold_valid && is_get && rsp_valid)
    else $error("request stalled without cause");

endmodule

`default_nettype wire
